[rtl/sexp_scan_pkg.sv]
package sexp_scan_pkg;

  localparam int unsigned PosBits     = 16;
  localparam int unsigned LenBits     = 8;
  localparam int unsigned KindBits    = 5;
  localparam int unsigned MaxTokenLen = 255;
  localparam int unsigned NumKeywords = 13;
  localparam int unsigned PrefixBytes = 8;

  localparam logic [KindBits-1:0] KIND_OPEN  = 5'd13;
  localparam logic [KindBits-1:0] KIND_CLOSE = 5'd14;
  localparam logic [KindBits-1:0] KIND_ARROW = 5'd15;
  localparam logic [KindBits-1:0] KIND_VAR   = 5'd16;
  localparam logic [KindBits-1:0] KIND_NUM   = 5'd17;
  localparam logic [KindBits-1:0] KIND_ID    = 5'd18;
  localparam logic [KindBits-1:0] KIND_END   = 5'd19;

  localparam logic [7:0] CHAR_NL     = 8'h0a;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_SEMI   = 8'h3b;
  localparam logic [7:0] CHAR_LT     = 8'h3c;
  localparam logic [7:0] CHAR_EQ     = 8'h3d;
  localparam logic [7:0] CHAR_QUEST  = 8'h3f;
  localparam logic [7:0] CHAR_OPEN   = 8'h28;
  localparam logic [7:0] CHAR_CLOSE  = 8'h29;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  // Keyword text, first character in the lowest byte.
  localparam logic [63:0] KwText [NumKeywords] = '{
    64'h0000_0000_656c_6f72,  // role
    64'h0000_0000_6573_6162,  // base
    64'h0000_0074_7570_6e69,  // input
    64'h0000_0000_7469_6e69,  // init
    64'h0000_006c_6167_656c,  // legal
    64'h0000_0000_7478_656e,  // next
    64'h0000_0000_6c61_6f67,  // goal
    64'h6c61_6e69_6d72_6574,  // terminal
    64'h0000_0000_7365_6f64,  // does
    64'h0000_0000_6575_7274,  // true
    64'h0000_0000_0074_6f6e,  // not
    64'h0000_0000_0000_726f,  // or
    64'h7463_6e69_7473_6964   // distinct
  };

  localparam logic [LenBits-1:0] KwLen [NumKeywords] = '{
    8'd4, 8'd4, 8'd5, 8'd4, 8'd5, 8'd4, 8'd4, 8'd8, 8'd4, 8'd4, 8'd3, 8'd2, 8'd8
  };

  typedef struct packed {
    logic                 last;
    logic [PosBits-1:0]   column;
    logic [PosBits-1:0]   line;
    logic [LenBits-1:0]   length;
    logic [KindBits-1:0]  kind;
  } result_t;

  function automatic logic [KindBits-1:0] classify(input logic [63:0] prefix,
                                                   input logic [LenBits-1:0] count,
                                                   input logic all_digits);
    logic [KindBits-1:0] kind;
    logic                found;
    kind  = KIND_ID;
    found = 1'b0;
    for (int i = 0; i < NumKeywords; i++) begin
      if (!found && count == KwLen[i] && prefix == KwText[i]) begin
        kind  = KindBits'(i);
        found = 1'b1;
      end
    end
    if (!found) begin
      if (prefix[7:0] == CHAR_QUEST) begin
        kind = KIND_VAR;
      end else if (all_digits) begin
        kind = KIND_NUM;
      end
    end
    return kind;
  endfunction

  function automatic logic [PosBits-1:0] sat_inc(input logic [PosBits-1:0] v);
    return (v == {PosBits{1'b1}}) ? v : v + PosBits'(1);
  endfunction

endpackage

[rtl/s_expression_token_scanner_unit.sv]
// Lexer for an s-expression clause language, one text byte per transfer.
// The slave channel carries a character in s_axis_tdata and an end-of-input
// flag in s_axis_tuser; with the flag set the character is ignored, the
// pending token is flushed and an END token follows. The master channel
// carries one classified token per transfer: kind, length, start line and
// start column in m_axis_tdata, and tlast on the final token that a given
// input transfer caused.
// Each byte is scanned in the cycle it is taken and its tokens are written
// into a four-entry result queue, so a token is offered from the queue
// register and never in the cycle of the byte that ends it. The scanner
// takes one byte per cycle while the queue has room for two tokens; a byte
// that yields two tokens (a token ended by a bracket, or end of input after
// a token) stalls the input only when the receiver is slower than the input.
// When the receiver stalls, the queue fills and s_axis_tready drops; nothing
// is lost. Reset empties the queue, returns the scanner to idle between
// tokens and sets the line and column counters to zero.
module s_expression_token_scanner_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
  input  logic        s_axis_tuser,   // [0] end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] token_kind, [12:5] token_length, [28:13] start_line,
  // [44:29] start_column, [47:45] zero
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  localparam int unsigned PB = sexp_scan_pkg::PosBits;
  localparam int unsigned LB = sexp_scan_pkg::LenBits;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_TOKEN,
    MODE_COMMENT,
    MODE_CLAUSE
  } mode_e;

  mode_e                      mode_q, mode_d;
  logic [63:0]                prefix_q, prefix_d;
  logic [LB-1:0]              count_q, count_d;
  logic                       digits_q, digits_d;
  logic [PB-1:0]              line_q, line_d;
  logic [PB-1:0]              col_q, col_d;
  logic [PB-1:0]              sline_q, sline_d;
  logic [PB-1:0]              scol_q, scol_d;

  sexp_scan_pkg::result_t     fifo_q [4];
  logic [1:0]                 wr_ptr_q, rd_ptr_q;
  logic [2:0]                 fill_q, fill_d;

  sexp_scan_pkg::result_t     res0, res1, pend, brk, endr;
  logic [1:0]                 n_res;
  logic                       accept, pop;
  logic [7:0]                 c;
  logic                       ws, paren;

  assign s_axis_tready = (fill_q <= 3'd2);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (fill_q != 3'd0);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = {3'b000, fifo_q[rd_ptr_q].column, fifo_q[rd_ptr_q].line,
                          fifo_q[rd_ptr_q].length, fifo_q[rd_ptr_q].kind};
  assign m_axis_tlast  = fifo_q[rd_ptr_q].last;

  assign c     = s_axis_tdata;
  assign ws    = (c == sexp_scan_pkg::CHAR_SPACE) || (c == sexp_scan_pkg::CHAR_TAB) ||
                 (c == sexp_scan_pkg::CHAR_NL);
  assign paren = (c == sexp_scan_pkg::CHAR_OPEN) || (c == sexp_scan_pkg::CHAR_CLOSE);

  always_comb begin
    mode_d   = mode_q;
    prefix_d = prefix_q;
    count_d  = count_q;
    digits_d = digits_q;
    line_d   = line_q;
    col_d    = col_q;
    sline_d  = sline_q;
    scol_d   = scol_q;
    n_res    = 2'd0;

    pend.kind   = sexp_scan_pkg::classify(prefix_q, count_q, digits_q);
    pend.length = count_q;
    pend.line   = sexp_scan_pkg::sat_inc(sline_q);
    pend.column = scol_q;
    pend.last   = 1'b0;

    endr.kind   = sexp_scan_pkg::KIND_END;
    endr.length = '0;
    endr.line   = sexp_scan_pkg::sat_inc(line_q);
    endr.column = col_q;
    endr.last   = 1'b1;

    if (!s_axis_tuser) begin
      if (c == sexp_scan_pkg::CHAR_NL) begin
        line_d = sexp_scan_pkg::sat_inc(line_q);
        col_d  = '0;
      end else begin
        col_d = sexp_scan_pkg::sat_inc(col_q);
      end
    end

    brk.kind   = (c == sexp_scan_pkg::CHAR_OPEN) ? sexp_scan_pkg::KIND_OPEN :
                                                   sexp_scan_pkg::KIND_CLOSE;
    brk.length = LB'(1);
    brk.line   = sexp_scan_pkg::sat_inc(line_d);
    brk.column = col_d;
    brk.last   = 1'b1;

    res0 = pend;
    res1 = endr;

    if (s_axis_tuser) begin
      mode_d = MODE_IDLE;
      if (mode_q == MODE_TOKEN || mode_q == MODE_CLAUSE) begin
        n_res = 2'd2;
      end else begin
        res0  = endr;
        n_res = 2'd1;
      end
    end else begin
      case (mode_q)
        MODE_COMMENT: begin
          if (c == sexp_scan_pkg::CHAR_NL) begin
            mode_d = MODE_IDLE;
          end
        end
        MODE_IDLE: begin
          if (c == sexp_scan_pkg::CHAR_SEMI) begin
            mode_d = MODE_COMMENT;
          end else if (ws) begin
            mode_d = MODE_IDLE;
          end else if (paren) begin
            res0  = brk;
            n_res = 2'd1;
          end else begin
            sline_d  = line_d;
            scol_d   = col_d;
            prefix_d = {56'd0, c};
            count_d  = LB'(1);
            digits_d = (c >= sexp_scan_pkg::CHAR_ZERO) && (c <= sexp_scan_pkg::CHAR_NINE);
            mode_d   = (c == sexp_scan_pkg::CHAR_LT) ? MODE_CLAUSE : MODE_TOKEN;
          end
        end
        default: begin
          if (mode_q == MODE_CLAUSE && c == sexp_scan_pkg::CHAR_EQ) begin
            res0.kind   = sexp_scan_pkg::KIND_ARROW;
            res0.length = LB'(2);
            res0.last   = 1'b1;
            n_res       = 2'd1;
            mode_d      = MODE_IDLE;
          end else if (ws) begin
            res0.last = 1'b1;
            n_res     = 2'd1;
            mode_d    = MODE_IDLE;
          end else if (c == sexp_scan_pkg::CHAR_SEMI) begin
            res0.last = 1'b1;
            n_res     = 2'd1;
            mode_d    = MODE_COMMENT;
          end else if (paren) begin
            res1   = brk;
            n_res  = 2'd2;
            mode_d = MODE_IDLE;
          end else begin
            for (int i = 0; i < sexp_scan_pkg::PrefixBytes; i++) begin
              if (count_q == LB'(i)) begin
                prefix_d[8*i +: 8] = c;
              end
            end
            if (!((c >= sexp_scan_pkg::CHAR_ZERO) && (c <= sexp_scan_pkg::CHAR_NINE))) begin
              digits_d = 1'b0;
            end
            if (count_q < LB'(sexp_scan_pkg::MaxTokenLen)) begin
              count_d = count_q + LB'(1);
            end
            mode_d = MODE_TOKEN;
          end
        end
      endcase
    end

    fill_d = fill_q + (accept ? {1'b0, n_res} : 3'd0) - {2'b00, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      prefix_q <= '0;
      count_q  <= '0;
      digits_q <= 1'b1;
      line_q   <= '0;
      col_q    <= '0;
      sline_q  <= '0;
      scol_q   <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (accept) begin
        mode_q   <= mode_d;
        prefix_q <= prefix_d;
        count_q  <= count_d;
        digits_q <= digits_d;
        line_q   <= line_d;
        col_q    <= col_d;
        sline_q  <= sline_d;
        scol_q   <= scol_d;
        wr_ptr_q <= wr_ptr_q + n_res;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && n_res != 2'd0) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (accept && n_res == 2'd2) begin
      fifo_q[wr_ptr_q + 2'd1] <= res1;
    end
  end

endmodule
